>>> rtl/c8alu_pkg.sv
package c8alu_pkg;

	// Operation codes; codes above MODE_SET pass the operand and flags through.
	localparam logic [4:0] MODE_ADD  = 5'd0;
	localparam logic [4:0] MODE_ADC  = 5'd1;
	localparam logic [4:0] MODE_SUB  = 5'd2;
	localparam logic [4:0] MODE_SBC  = 5'd3;
	localparam logic [4:0] MODE_CP   = 5'd4;
	localparam logic [4:0] MODE_INC  = 5'd5;
	localparam logic [4:0] MODE_DEC  = 5'd6;
	localparam logic [4:0] MODE_RLC  = 5'd7;
	localparam logic [4:0] MODE_RRC  = 5'd8;
	localparam logic [4:0] MODE_RL   = 5'd9;
	localparam logic [4:0] MODE_RR   = 5'd10;
	localparam logic [4:0] MODE_SLA  = 5'd11;
	localparam logic [4:0] MODE_SRA  = 5'd12;
	localparam logic [4:0] MODE_SWAP = 5'd13;
	localparam logic [4:0] MODE_SRL  = 5'd14;
	localparam logic [4:0] MODE_BIT  = 5'd15;
	localparam logic [4:0] MODE_RES  = 5'd16;
	localparam logic [4:0] MODE_SET  = 5'd17;
	localparam logic [4:0] MODE_PASS = 5'd18;

	typedef struct packed {
		logic [4:0] mode;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic [2:0] bit_sel;
		logic       zero_in;
		logic       subtract_in;
		logic       half_carry_in;
		logic       carry_in;
	} op_t;

	typedef struct packed {
		logic [7:0] result;
		logic       zero_out;
		logic       subtract_out;
		logic       half_carry_out;
		logic       carry_out;
	} res_t;

	// Stage 1: operands prepared for the shared adder, bit mask decoded.
	typedef struct packed {
		logic [4:0] mode;
		logic [7:0] a;
		logic [7:0] addend;
		logic       cin;
		logic       borrow;
		logic [7:0] mask;
		logic       z;
		logic       n;
		logic       h;
		logic       c;
	} s1_t;

	// Stage 2: result byte and flags, zero flag still to be resolved.
	typedef struct packed {
		logic [7:0] result;
		logic [7:0] zbyte;
		logic       z_from_byte;
		logic       z_fixed;
		logic       n;
		logic       h;
		logic       c;
	} s2_t;

endpackage

>>> rtl/c8alu_prep.sv
module c8alu_prep (
	input  logic           clk,
	input  logic           en,
	input  c8alu_pkg::op_t op,
	output c8alu_pkg::s1_t data_s1
);
	import c8alu_pkg::*;

	s1_t nxt;

	always_comb begin
		nxt        = '0;
		nxt.mode   = op.mode;
		nxt.a      = op.operand_a;
		nxt.mask   = 8'b0000_0001 << op.bit_sel;
		nxt.z      = op.zero_in;
		nxt.n      = op.subtract_in;
		nxt.h      = op.half_carry_in;
		nxt.c      = op.carry_in;
		nxt.addend = op.operand_b;
		nxt.cin    = 1'b0;
		nxt.borrow = 1'b0;
		// subtract as a + ~b + 1 - carry; carries then read as inverted borrows
		unique case (op.mode) inside
			MODE_ADC: begin
				nxt.cin = op.carry_in;
			end
			MODE_SUB, MODE_CP: begin
				nxt.addend = ~op.operand_b;
				nxt.cin    = 1'b1;
				nxt.borrow = 1'b1;
			end
			MODE_SBC: begin
				nxt.addend = ~op.operand_b;
				nxt.cin    = ~op.carry_in;
				nxt.borrow = 1'b1;
			end
			MODE_INC: begin
				nxt.addend = 8'h00;
				nxt.cin    = 1'b1;
			end
			MODE_DEC: begin
				nxt.addend = 8'hFF;
				nxt.borrow = 1'b1;
			end
			default: begin
				nxt.cin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

>>> rtl/c8alu_exec.sv
module c8alu_exec (
	input  logic           clk,
	input  logic           en,
	input  c8alu_pkg::s1_t data_s1,
	output c8alu_pkg::s2_t data_s2
);
	import c8alu_pkg::*;

	logic [4:0] lo;
	logic [8:0] sum;
	logic       hc;
	logic       cc;
	s2_t        nxt;

	assign lo  = {1'b0, data_s1.a[3:0]} + {1'b0, data_s1.addend[3:0]} + {4'b0, data_s1.cin};
	assign sum = {1'b0, data_s1.a} + {1'b0, data_s1.addend} + {8'b0, data_s1.cin};
	assign hc  = lo[4] ^ data_s1.borrow;
	assign cc  = sum[8] ^ data_s1.borrow;

	always_comb begin
		nxt             = '0;
		nxt.result      = data_s1.a;
		nxt.zbyte       = data_s1.a;
		nxt.z_from_byte = 1'b1;
		nxt.z_fixed     = data_s1.z;
		nxt.n           = 1'b0;
		nxt.h           = 1'b0;
		nxt.c           = data_s1.c;
		unique case (data_s1.mode) inside
			MODE_ADD, MODE_ADC: begin
				nxt.result = sum[7:0];
				nxt.zbyte  = sum[7:0];
				nxt.h      = hc;
				nxt.c      = cc;
			end
			MODE_SUB, MODE_SBC: begin
				nxt.result = sum[7:0];
				nxt.zbyte  = sum[7:0];
				nxt.n      = 1'b1;
				nxt.h      = hc;
				nxt.c      = cc;
			end
			MODE_CP: begin
				nxt.zbyte = sum[7:0];
				nxt.n     = 1'b1;
				nxt.h     = hc;
				nxt.c     = cc;
			end
			MODE_INC, MODE_DEC: begin
				nxt.result = sum[7:0];
				nxt.zbyte  = sum[7:0];
				nxt.n      = data_s1.borrow;
				nxt.h      = hc;
			end
			MODE_RLC: begin
				nxt.result = {data_s1.a[6:0], data_s1.a[7]};
				nxt.zbyte  = nxt.result;
				nxt.c      = data_s1.a[7];
			end
			MODE_RRC: begin
				nxt.result = {data_s1.a[0], data_s1.a[7:1]};
				nxt.zbyte  = nxt.result;
				nxt.c      = data_s1.a[0];
			end
			MODE_RL: begin
				nxt.result = {data_s1.a[6:0], data_s1.c};
				nxt.zbyte  = nxt.result;
				nxt.c      = data_s1.a[7];
			end
			MODE_RR: begin
				nxt.result = {data_s1.c, data_s1.a[7:1]};
				nxt.zbyte  = nxt.result;
				nxt.c      = data_s1.a[0];
			end
			MODE_SLA: begin
				nxt.result = {data_s1.a[6:0], 1'b0};
				nxt.zbyte  = nxt.result;
				nxt.c      = data_s1.a[7];
			end
			MODE_SRA: begin
				nxt.result = {data_s1.a[7], data_s1.a[7:1]};
				nxt.zbyte  = nxt.result;
				nxt.c      = data_s1.a[0];
			end
			MODE_SWAP: begin
				nxt.result = {data_s1.a[3:0], data_s1.a[7:4]};
				nxt.zbyte  = nxt.result;
				nxt.c      = 1'b0;
			end
			MODE_SRL: begin
				nxt.result = {1'b0, data_s1.a[7:1]};
				nxt.zbyte  = nxt.result;
				nxt.c      = data_s1.a[0];
			end
			MODE_BIT: begin
				nxt.z_from_byte = 1'b0;
				nxt.z_fixed     = ~|(data_s1.a & data_s1.mask);
				nxt.h           = 1'b1;
			end
			MODE_RES: begin
				nxt.result      = data_s1.a & ~data_s1.mask;
				nxt.z_from_byte = 1'b0;
				nxt.n           = data_s1.n;
				nxt.h           = data_s1.h;
			end
			MODE_SET: begin
				nxt.result      = data_s1.a | data_s1.mask;
				nxt.z_from_byte = 1'b0;
				nxt.n           = data_s1.n;
				nxt.h           = data_s1.h;
			end
			default: begin
				// pass and unused codes keep every flag
				nxt.z_from_byte = 1'b0;
				nxt.n           = data_s1.n;
				nxt.h           = data_s1.h;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt;
		end
	end

endmodule

>>> rtl/c8alu_fin.sv
module c8alu_fin (
	input  logic            clk,
	input  logic            en,
	input  c8alu_pkg::s2_t  data_s2,
	output c8alu_pkg::res_t data_s3
);
	import c8alu_pkg::*;

	res_t nxt;

	always_comb begin
		nxt.result         = data_s2.result;
		nxt.zero_out       = data_s2.z_from_byte ? (data_s2.zbyte == 8'h00) : data_s2.z_fixed;
		nxt.subtract_out   = data_s2.n;
		nxt.half_carry_out = data_s2.h;
		nxt.carry_out      = data_s2.c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s3 <= nxt;
		end
	end

endmodule

>>> rtl/cpu8_alu_with_flags.sv
// 8-bit CPU ALU with Z, N, H and C flags. Each beat on the op channel carries
// an operation code, two operand bytes, a bit index and the incoming flags;
// each beat on the res channel returns the result byte and the new flags, in
// order, one result per operation. The block is a three-stage pipeline:
// operand preparation and bit-mask decode, the shared 8-bit adder with the
// shift and bit units, then zero detection into the output register. It takes
// one beat every cycle while op_stall is low; an accepted operation passes
// through the stage 1, stage 2 and output registers before res_valid rises.
// A stall on the result side holds the pipeline, and op_stall rises only
// when every stage is full. Codes 18 and above return operand_a with the flags
// unchanged.
module cpu8_alu_with_flags (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	output logic             op_stall,
	input  c8alu_pkg::op_t   op,
	output logic             res_valid,
	input  logic             res_stall,
	output c8alu_pkg::res_t  res
);
	import c8alu_pkg::*;

	s1_t  data_s1;
	s2_t  data_s2;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic en1;
	logic en2;
	logic en3;

	// advance a stage when it is empty or its contents move on
	assign en3      = ~valid_s3 | ~res_stall;
	assign en2      = ~valid_s2 | en3;
	assign en1      = ~valid_s1 | en2;
	assign op_stall = ~en1;
	assign res_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= op_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	c8alu_prep u_prep (
		.clk     (clk),
		.en      (en1 & op_valid),
		.op      (op),
		.data_s1 (data_s1)
	);

	c8alu_exec u_exec (
		.clk     (clk),
		.en      (en2 & valid_s1),
		.data_s1 (data_s1),
		.data_s2 (data_s2)
	);

	c8alu_fin u_fin (
		.clk     (clk),
		.en      (en3 & valid_s2),
		.data_s2 (data_s2),
		.data_s3 (res)
	);

endmodule

>>> rtl/c8alu_chk.sv
module c8alu_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            op_valid,
	input logic            op_stall,
	input c8alu_pkg::op_t  op,
	input logic            res_valid,
	input logic            res_stall,
	input c8alu_pkg::res_t res
);
	import c8alu_pkg::*;

	// hold a stalled result beat
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result beat dropped or changed");

	// never stall the op side while the result side drains
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_stall |-> !op_stall)
		else $error("op_stall high while result side is free");

	// an accepted beat reaches res_valid while the result side does not stall
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid && !op_stall) ##1 !res_stall ##1 !res_stall |=> res_valid)
		else $error("result missing after pipeline latency");

	// nothing comes out of an empty pipeline
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(op_valid, 1) && !$past(op_valid, 2) && !$past(op_valid, 3)
		&& !$past(res_valid, 1) |-> !res_valid)
		else $error("result beat with no operation in flight");

endmodule

bind cpu8_alu_with_flags c8alu_chk u_chk (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the 8-bit CPU ALU with flags.
// A directed run covers operand extremes, every operation and the pass-through
// codes. Then random runs target the arithmetic, the shift and rotate unit, the
// bit operations and the whole 5-bit code space. Each random run steps through
// four idle patterns on the op and res channels. A monitor predicts each
// accepted op beat and compares every res beat with the oldest prediction.
module tb_top;

	import c8alu_pkg::*;

	// Operation families for random stimulus
	localparam int KIND_ARITH = 0;
	localparam int KIND_SHIFT = 1;
	localparam int KIND_BITOP = 2;
	localparam int KIND_ANY   = 3;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 16;

	logic clk;
	logic arst_n;
	logic op_valid;
	logic op_stall;
	op_t  op;
	logic res_valid;
	logic res_stall;
	res_t res;

	// Predicted results, oldest first
	res_t alu_expected[$];

	int send_idle_pct;
	int recv_stall_pct;
	int fail_count;
	int cycle_count;

	cpu8_alu_with_flags i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.op        (op),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Compute the result byte and new flags for one operation.
	function automatic res_t predict_alu(input op_t o);
		res_t       r;
		logic [8:0] sum;
		logic [4:0] nib;
		logic [7:0] diff;
		logic       cy;
		logic [7:0] a;
		logic [7:0] b;

		a = o.operand_a;
		b = o.operand_b;
		r.result         = a;
		r.zero_out       = o.zero_in;
		r.subtract_out   = o.subtract_in;
		r.half_carry_out = o.half_carry_in;
		r.carry_out      = o.carry_in;
		case (o.mode) inside
			MODE_ADD, MODE_ADC: begin
				cy = (o.mode == MODE_ADC) ? o.carry_in : 1'b0;
				sum = {1'b0, a} + {1'b0, b} + {8'd0, cy};
				nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
				r.result = sum[7:0];
				r.half_carry_out = nib[4];
				r.carry_out = sum[8];
				r.zero_out = (sum[7:0] == 8'd0);
				r.subtract_out = 1'b0;
			end
			MODE_SUB, MODE_SBC, MODE_CP: begin
				cy = (o.mode == MODE_SBC) ? o.carry_in : 1'b0;
				nib = {1'b0, b[3:0]} + {4'd0, cy};
				sum = {1'b0, b} + {8'd0, cy};
				diff = a - b - {7'd0, cy};
				r.half_carry_out = ({1'b0, a[3:0]} < nib);
				r.carry_out = ({1'b0, a} < sum);
				r.zero_out = (diff == 8'd0);
				r.subtract_out = 1'b1;
				r.result = (o.mode == MODE_CP) ? a : diff;
			end
			MODE_INC: begin
				r.result = a + 8'd1;
				r.half_carry_out = (a[3:0] == 4'hF);
				r.zero_out = (r.result == 8'd0);
				r.subtract_out = 1'b0;
			end
			MODE_DEC: begin
				r.result = a - 8'd1;
				r.half_carry_out = (a[3:0] == 4'h0);
				r.zero_out = (r.result == 8'd0);
				r.subtract_out = 1'b1;
			end
			MODE_RLC, MODE_RRC, MODE_RL, MODE_RR, MODE_SLA, MODE_SRA, MODE_SRL: begin
				case (o.mode)
					MODE_RLC: begin
						r.result = {a[6:0], a[7]};
						r.carry_out = a[7];
					end
					MODE_RRC: begin
						r.result = {a[0], a[7:1]};
						r.carry_out = a[0];
					end
					MODE_RL: begin
						r.result = {a[6:0], o.carry_in};
						r.carry_out = a[7];
					end
					MODE_RR: begin
						r.result = {o.carry_in, a[7:1]};
						r.carry_out = a[0];
					end
					MODE_SLA: begin
						r.result = {a[6:0], 1'b0};
						r.carry_out = a[7];
					end
					MODE_SRA: begin
						r.result = {a[7], a[7:1]};
						r.carry_out = a[0];
					end
					default: begin
						r.result = {1'b0, a[7:1]};
						r.carry_out = a[0];
					end
				endcase
				r.zero_out = (r.result == 8'd0);
				r.subtract_out = 1'b0;
				r.half_carry_out = 1'b0;
			end
			MODE_SWAP: begin
				r.result = {a[3:0], a[7:4]};
				r.zero_out = (r.result == 8'd0);
				r.subtract_out = 1'b0;
				r.half_carry_out = 1'b0;
				r.carry_out = 1'b0;
			end
			MODE_BIT: begin
				r.zero_out = ~a[o.bit_sel];
				r.subtract_out = 1'b0;
				r.half_carry_out = 1'b1;
			end
			MODE_RES: r.result = a & ~(8'd1 << o.bit_sel);
			MODE_SET: r.result = a | (8'd1 << o.bit_sel);
			default: ;
		endcase
		return r;
	endfunction

	function automatic op_t make_op(input logic [4:0] mode, input logic [7:0] a,
		input logic [7:0] b, input logic [2:0] idx, input logic [3:0] znhc);
		op_t o;

		o.mode          = mode;
		o.operand_a     = a;
		o.operand_b     = b;
		o.bit_sel       = idx;
		o.zero_in       = znhc[3];
		o.subtract_in   = znhc[2];
		o.half_carry_in = znhc[1];
		o.carry_in      = znhc[0];
		return o;
	endfunction

	// Favor bytes at nibble and sign boundaries a quarter of the time.
	function automatic logic [7:0] pick_byte();
		logic [7:0] v;

		v = 8'($urandom);
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(6))
				0: v = 8'h00;
				1: v = 8'hFF;
				2: v = 8'h0F;
				3: v = 8'hF0;
				4: v = 8'h80;
				5: v = 8'h7F;
				default: v = 8'h01;
			endcase
		end
		return v;
	endfunction

	function automatic op_t rand_op(input int kind);
		op_t o;

		o = make_op(5'd0, pick_byte(), pick_byte(), 3'($urandom), 4'($urandom));
		case (kind)
			KIND_ARITH: o.mode = 5'($urandom_range(MODE_DEC, MODE_ADD));
			KIND_SHIFT: o.mode = 5'($urandom_range(MODE_SRL, MODE_RLC));
			KIND_BITOP: o.mode = 5'($urandom_range(MODE_SET, MODE_BIT));
			default:    o.mode = 5'($urandom_range(31, 0));
		endcase
		return o;
	endfunction

	// Pick the idle pattern for one quarter of a random run.
	task automatic set_idling(input int phase);
		case (phase)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 47;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 47;
			end
			default: begin
				send_idle_pct  = 35;
				recv_stall_pct = 35;
			end
		endcase
	endtask

	// Present one op beat from a falling edge and hold it until accepted.
	// Return on the falling edge after acceptance, so the next call can keep
	// valid high without a gap.
	task automatic send_op(input op_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			op_valid <= 1'b0;
			@(negedge clk);
		end
		op_valid <= 1'b1;
		op       <= item;
		@(posedge clk);
		while (op_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(input int kind, input int count);
		for (int i = 0; i < count; i++) begin
			set_idling((i * 4) / count);
			send_op(rand_op(kind));
		end
	endtask

	task automatic test_directed();
		set_idling(0);
		// Carry out of both nibbles with a zero result
		send_op(make_op(MODE_ADD, 8'hFF, 8'h01, 3'd0, 4'b0000));
		send_op(make_op(MODE_ADD, 8'h00, 8'h00, 3'd0, 4'b1111));
		send_op(make_op(MODE_ADC, 8'h0F, 8'h00, 3'd0, 4'b0001));
		send_op(make_op(MODE_ADC, 8'hFF, 8'hFF, 3'd7, 4'b0001));
		send_op(make_op(MODE_SUB, 8'h3C, 8'h3C, 3'd0, 4'b0000));
		// Borrow from bit 4 only
		send_op(make_op(MODE_SUB, 8'h10, 8'h01, 3'd0, 4'b0000));
		send_op(make_op(MODE_SBC, 8'h00, 8'hFF, 3'd0, 4'b0001));
		send_op(make_op(MODE_SBC, 8'h01, 8'h00, 3'd0, 4'b0001));
		send_op(make_op(MODE_CP, 8'h42, 8'h43, 3'd0, 4'b0000));
		send_op(make_op(MODE_INC, 8'hFF, 8'h00, 3'd0, 4'b0001));
		send_op(make_op(MODE_INC, 8'h0F, 8'h00, 3'd0, 4'b0000));
		send_op(make_op(MODE_DEC, 8'h00, 8'h00, 3'd0, 4'b0000));
		send_op(make_op(MODE_DEC, 8'h01, 8'h00, 3'd0, 4'b0001));
		send_op(make_op(MODE_RLC, 8'h80, 8'h00, 3'd0, 4'b1110));
		send_op(make_op(MODE_RRC, 8'h01, 8'h00, 3'd0, 4'b0000));
		// Rotate through carry leaving zero behind
		send_op(make_op(MODE_RL, 8'h80, 8'h00, 3'd0, 4'b0000));
		send_op(make_op(MODE_RR, 8'h01, 8'h00, 3'd0, 4'b0001));
		send_op(make_op(MODE_SLA, 8'hFF, 8'h00, 3'd0, 4'b0000));
		send_op(make_op(MODE_SRA, 8'h81, 8'h00, 3'd0, 4'b0000));
		send_op(make_op(MODE_SWAP, 8'hF0, 8'h00, 3'd0, 4'b1111));
		send_op(make_op(MODE_SRL, 8'h01, 8'h00, 3'd0, 4'b0000));
		send_op(make_op(MODE_BIT, 8'h7F, 8'h00, 3'd7, 4'b0001));
		send_op(make_op(MODE_RES, 8'h01, 8'h00, 3'd0, 4'b1010));
		send_op(make_op(MODE_SET, 8'h00, 8'h00, 3'd7, 4'b0101));
		// Pass-through and unused codes keep operand and flags
		send_op(make_op(MODE_PASS, 8'hA5, 8'h5A, 3'd3, 4'b1111));
		send_op(make_op(5'd31, 8'h00, 8'hFF, 3'd7, 4'b0110));
	endtask

	task automatic test_arith();
		run_random(KIND_ARITH, 500);
	endtask

	task automatic test_shift_rotate();
		run_random(KIND_SHIFT, 450);
	endtask

	task automatic test_bit_ops();
		run_random(KIND_BITOP, 400);
	endtask

	task automatic test_any_code();
		run_random(KIND_ANY, 500);
	endtask

	// Drive the receiver stall from a falling edge.
	always @(negedge clk) begin
		if (arst_n)
			res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Predict each accepted op beat, then check each accepted res beat.
	always @(posedge clk) begin
		res_t want;

		if (arst_n) begin
			if (op_valid && !op_stall)
				alu_expected.push_back(predict_alu(op));
			if (res_valid && !res_stall) begin
				if (alu_expected.size() == 0) begin
					$error("result beat with nothing expected: %02h", res.result);
					fail_count++;
				end else begin
					want = alu_expected.pop_front();
					if (res.result !== want.result) begin
						$error("result: expected %02h, actual %02h", want.result, res.result);
						fail_count++;
					end
					if (res.zero_out !== want.zero_out) begin
						$error("zero_out: expected %0b, actual %0b", want.zero_out,
							res.zero_out);
						fail_count++;
					end
					if (res.subtract_out !== want.subtract_out) begin
						$error("subtract_out: expected %0b, actual %0b", want.subtract_out,
							res.subtract_out);
						fail_count++;
					end
					if (res.half_carry_out !== want.half_carry_out) begin
						$error("half_carry_out: expected %0b, actual %0b",
							want.half_carry_out, res.half_carry_out);
						fail_count++;
					end
					if (res.carry_out !== want.carry_out) begin
						$error("carry_out: expected %0b, actual %0b", want.carry_out,
							res.carry_out);
						fail_count++;
					end
				end
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		op_valid       = 1'b0;
		op             = '0;
		res_stall      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fail_count     = 0;
		cycle_count    = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_arith();
		test_shift_rotate();
		test_bit_ops();
		test_any_code();

		// Drop valid and release the receiver, then drain the pipeline.
		op_valid <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (alu_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
